// ===== hw/rtl/sba_pkg.sv =====
// ----------------------------------------------------------------------------
// sba_pkg
// Shared types and constants for the slab bitmap slot allocator.
// ----------------------------------------------------------------------------
package sba_pkg;

  localparam int ADDR_W    = 13;
  localparam int SIZE_W    = 14;
  localparam int CNT_W     = 13;
  localparam int CFG_W     = 14;
  localparam int CFG_IDX_W = 2;

  localparam int MAX_SLOTS_DEFAULT = 4096;
  // word width of the bitmap memory; a power of two
  localparam int WORD_BITS_DEFAULT = 64;

  localparam logic [SIZE_W-1:0] OBJ_BYTES_RESET = SIZE_W'(8);

  localparam logic [CFG_IDX_W-1:0] REG_OBJ_BYTES   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SLOT_TOTAL  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_OBJECT_BASE = 2'd2;

  localparam logic FUNC_ALLOC = 1'b0;
  localparam logic FUNC_FREE  = 1'b1;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_FULL     = 2'd1;
  localparam logic [1:0] ST_BAD_FREE = 2'd2;

  typedef struct packed {
    logic              func;
    logic [ADDR_W-1:0] free_address;
  } sba_req_t;

  typedef struct packed {
    logic [1:0]        status;
    logic [ADDR_W-1:0] object_address;
    logic [CNT_W-1:0]  free_slots;
  } sba_rsp_t;

endpackage

// ===== hw/rtl/slab_bitmap_slot_allocator.sv =====
// ----------------------------------------------------------------------------
// slab_bitmap_slot_allocator
// Occupancy bitmap allocator for one slab of fixed-size objects.
// ----------------------------------------------------------------------------
// Request channel (in_valid/in_stall/in_data): one item is an allocate or a
// free. Response channel (out_valid/out_stall/out_data): exactly one item per
// request, in order, with status, object address and the free count after it.
// The bitmap lives in a simple dual-port memory of NUM_WORDS words of
// WORD_BITS bits with a registered read; one request is worked on at a time.
// Allocate: the scan reads one word per cycle, pipelined with the check. The
//   lowest clear bit of the first non-full word is set, the object address is
//   then formed in S_MUL and the response is registered from S_DONE.
// Free: a restoring divider produces one quotient bit per cycle for the
//   13-bit offset, then a read and a write-back of the bitmap word.
// A full slab, an offset below base or a zero size go straight to the response.
// in_stall is high while a request is in flight; a finished response sits in
// the output register while the next request is taken, and a stalled
// response holds until the receiver takes it.
// Reset, and every write to the slot count, run a clearing pass over all
// NUM_WORDS words that zeroes the bitmap; no request is taken then.
// Configuration writes take effect at once; the user must make them only while idle, as the block does not enforce it.
// ----------------------------------------------------------------------------
module slab_bitmap_slot_allocator #(
  parameter int MAX_SLOTS = sba_pkg::MAX_SLOTS_DEFAULT,
  parameter int WORD_BITS = sba_pkg::WORD_BITS_DEFAULT
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_write,
  input  logic [sba_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [sba_pkg::CFG_W-1:0]     cfg_data,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  sba_pkg::sba_req_t             in_data,
  output logic                          out_valid,
  input  logic                          out_stall,
  output sba_pkg::sba_rsp_t             out_data
);
  import sba_pkg::*;

  localparam int NUM_WORDS = (MAX_SLOTS + WORD_BITS - 1) / WORD_BITS;
  localparam int WA        = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
  localparam int BIT_W     = $clog2(WORD_BITS);
  localparam int SLOT_W    = WA + BIT_W;
  localparam int DIV_CW    = $clog2(ADDR_W);
  localparam logic [WA-1:0]     LAST_WORD = WA'(NUM_WORDS - 1);
  localparam logic [CNT_W:0]    LIMIT_CAP = (CNT_W+1)'(MAX_SLOTS);
  localparam logic [DIV_CW-1:0] DIV_LAST  = DIV_CW'(ADDR_W - 1);

  localparam logic [2:0] S_CLR      = 3'd0;
  localparam logic [2:0] S_IDLE     = 3'd1;
  localparam logic [2:0] S_SCAN     = 3'd2;
  localparam logic [2:0] S_MUL      = 3'd3;
  localparam logic [2:0] S_DIV      = 3'd4;
  localparam logic [2:0] S_FREE_RD  = 3'd5;
  localparam logic [2:0] S_FREE_CHK = 3'd6;
  localparam logic [2:0] S_DONE     = 3'd7;

  // configuration
  logic [SIZE_W-1:0] obj_bytes;
  logic [CNT_W-1:0]  slot_total;
  logic [ADDR_W-1:0] object_base;

  logic [2:0]        state;
  logic [CNT_W-1:0]  free_counter;
  logic [WA-1:0]     clr_idx;
  logic [WA-1:0]     scan_idx;
  logic [WA-1:0]     chk_idx;
  logic              rd_pend;
  logic [SLOT_W-1:0] slot;
  logic [ADDR_W-1:0] prod;
  logic [1:0]        res_status;
  logic              add_base;

  // divider
  logic [SIZE_W-1:0] rem;
  logic [ADDR_W-1:0] quo;
  logic [DIV_CW-1:0] div_cnt;
  logic [SIZE_W+1:0] trial;
  logic              trial_ok;

  // bitmap memory
  logic [WORD_BITS-1:0] bitmap_mem [NUM_WORDS];
  logic [WORD_BITS-1:0] rd_data;
  logic                 mem_we;
  logic [WA-1:0]        mem_waddr;
  logic [WA-1:0]        mem_raddr;
  logic [WORD_BITS-1:0] mem_wdata;

  logic [CNT_W-1:0]     slot_limit;
  logic [CNT_W-1:0]     new_limit;
  logic                 found;
  logic [WORD_BITS-1:0] zero_1h;
  logic [BIT_W-1:0]     zero_bit;
  logic [WORD_BITS-1:0] clr_mask;
  logic                 slot_used;
  logic [ADDR_W+SIZE_W-1:0] mul;

  assign slot_limit = ({1'b0, slot_total} >= LIMIT_CAP) ? LIMIT_CAP[CNT_W-1:0] : slot_total;
  assign new_limit  = ({1'b0, cfg_data[CNT_W-1:0]} >= LIMIT_CAP) ? LIMIT_CAP[CNT_W-1:0]
                                                                 : cfg_data[CNT_W-1:0];

  assign in_stall = (state != S_IDLE);

  // lowest clear bit of the word under check
  assign found   = rd_pend && (rd_data != '1);
  assign zero_1h = ~rd_data & (rd_data + WORD_BITS'(1));

  always_comb begin
    zero_bit = '0;
    for (int i = 0; i < WORD_BITS; i++) begin
      if (zero_1h[i]) begin
        zero_bit = zero_bit | BIT_W'(i);
      end
    end
  end

  assign clr_mask  = WORD_BITS'(1) << slot[BIT_W-1:0];
  assign slot_used = rd_data[slot[BIT_W-1:0]];
  assign mul       = (ADDR_W+SIZE_W)'(slot) * (ADDR_W+SIZE_W)'(obj_bytes);

  assign trial    = {1'b0, rem, quo[ADDR_W-1]} - {2'b00, obj_bytes};
  assign trial_ok = !trial[SIZE_W+1];

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = clr_idx;
    mem_wdata = '0;
    mem_raddr = scan_idx;
    case (state)
      S_CLR: begin
        mem_we = 1'b1;
      end
      S_SCAN: begin
        if (found) begin
          mem_we    = 1'b1;
          mem_waddr = chk_idx;
          mem_wdata = rd_data | zero_1h;
        end
      end
      S_FREE_RD: begin
        mem_raddr = quo[SLOT_W-1:BIT_W];
      end
      S_FREE_CHK: begin
        if (slot_used) begin
          mem_we    = 1'b1;
          mem_waddr = slot[SLOT_W-1:BIT_W];
          mem_wdata = rd_data & ~clr_mask;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      bitmap_mem[mem_waddr] <= mem_wdata;
    end
    rd_data <= bitmap_mem[mem_raddr];
  end

  // payload registers
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        rem     <= '0;
        quo     <= in_data.free_address - object_base;
        div_cnt <= DIV_LAST;
        if (in_data.func == FUNC_ALLOC) begin
          res_status <= (free_counter == '0) ? ST_FULL : ST_OK;
          add_base   <= (free_counter != '0);
        end else begin
          res_status <= (in_data.free_address < object_base || obj_bytes == '0)
                        ? ST_BAD_FREE : ST_OK;
          add_base   <= 1'b0;
        end
      end
      S_SCAN: begin
        chk_idx <= scan_idx;
        if (found) begin
          slot <= {chk_idx, zero_bit};
        end
      end
      S_MUL: begin
        prod <= mul[ADDR_W-1:0];
      end
      S_DIV: begin
        rem     <= trial_ok ? trial[SIZE_W-1:0] : {rem[SIZE_W-2:0], quo[ADDR_W-1]};
        quo     <= {quo[ADDR_W-2:0], trial_ok};
        div_cnt <= div_cnt - DIV_CW'(1);
      end
      S_FREE_RD: begin
        slot <= quo[SLOT_W-1:0];
        if (quo >= slot_limit) begin
          res_status <= ST_BAD_FREE;
        end
      end
      S_FREE_CHK: begin
        if (!slot_used) begin
          res_status <= ST_BAD_FREE;
        end
      end
      default: begin
      end
    endcase
    if (state == S_DONE && (!out_valid || !out_stall)) begin
      out_data.status         <= res_status;
      out_data.object_address <= add_base ? object_base + prod : '0;
      out_data.free_slots     <= free_counter;
    end
  end

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      obj_bytes    <= OBJ_BYTES_RESET;
      slot_total   <= '0;
      object_base  <= '0;
      free_counter <= '0;
      state        <= S_CLR;
      clr_idx      <= '0;
      scan_idx     <= '0;
      rd_pend      <= 1'b0;
      out_valid    <= 1'b0;
    end else begin
      if (state == S_DONE && (!out_valid || !out_stall)) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end

      if (cfg_write && cfg_index == REG_SLOT_TOTAL) begin
        // a new slot count starts the slab over
        free_counter <= new_limit;
        clr_idx      <= '0;
        state        <= S_CLR;
      end else begin
        case (state)
          S_CLR: begin
            clr_idx <= clr_idx + WA'(1);
            if (clr_idx == LAST_WORD) begin
              state <= S_IDLE;
            end
          end
          S_IDLE: begin
            scan_idx <= '0;
            rd_pend  <= 1'b0;
            if (in_valid) begin
              if (in_data.func == FUNC_ALLOC) begin
                state <= (free_counter == '0) ? S_DONE : S_SCAN;
              end else if (in_data.free_address < object_base || obj_bytes == '0) begin
                state <= S_DONE;
              end else begin
                state <= S_DIV;
              end
            end
          end
          S_SCAN: begin
            // read of the next word overlaps the check of the previous one
            scan_idx <= scan_idx + WA'(1);
            rd_pend  <= 1'b1;
            if (found) begin
              free_counter <= free_counter - CNT_W'(1);
              state        <= S_MUL;
            end
          end
          S_MUL: begin
            state <= S_DONE;
          end
          S_DIV: begin
            if (div_cnt == '0) begin
              state <= S_FREE_RD;
            end
          end
          S_FREE_RD: begin
            state <= (quo >= slot_limit) ? S_DONE : S_FREE_CHK;
          end
          S_FREE_CHK: begin
            if (slot_used) begin
              free_counter <= free_counter + CNT_W'(1);
            end
            state <= S_DONE;
          end
          S_DONE: begin
            if (!out_valid || !out_stall) begin
              state <= S_IDLE;
            end
          end
          default: begin
            state <= S_IDLE;
          end
        endcase
      end

      if (cfg_write) begin
        case (cfg_index)
          REG_OBJ_BYTES: begin
            obj_bytes <= cfg_data;
          end
          REG_SLOT_TOTAL: begin
            slot_total <= cfg_data[CNT_W-1:0];
          end
          REG_OBJECT_BASE: begin
            object_base <= cfg_data[ADDR_W-1:0];
          end
          default: begin
          end
        endcase
      end
    end
  end

endmodule
